// ----- rtl/lwwr_pkg.sv -----
`timescale 1ns / 1ps
package lwwr_pkg;

    // The ring index and the queue pointers wrap naturally, so the window
    // depth is a power of two; the length fields hold the full depth.
    localparam int MAX_WINDOW = 1024;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int LEN_W      = 11;
    localparam int DATA_W     = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     last_sample;
    } t_in;

    typedef struct packed {
        logic [LEN_W-1:0] window_len;
        logic [LEN_W-1:0] best_len;
    } t_out;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ADDR_W-1:0]        slot;
    } t_qentry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE_RD,
        S_PRE_EVICT,
        S_TAIL_RD,
        S_PUSH,
        S_POST_RD,
        S_POST_EVICT,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic accept;
        logic pre;
        logic evict;
        logic push;
        logic shrink;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic evict_any;
        logic dom_any;
        logic in_range;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/lwwr_ram.sv -----
`timescale 1ns / 1ps
module lwwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- rtl/lwwr_ctrl.sv -----
`timescale 1ns / 1ps
module lwwr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lwwr_pkg::t_sts i_sts,
    output lwwr_pkg::t_cmd o_cmd
);
    import lwwr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_PRE_RD;
                end
            end
            S_PRE_RD: begin
                n_state = S_PRE_EVICT;
            end
            S_PRE_EVICT: begin
                o_cmd.pre   = 1'b1;
                o_cmd.evict = 1'b1;
                n_state     = i_sts.evict_any ? S_PRE_RD : S_TAIL_RD;
            end
            S_TAIL_RD: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = i_sts.dom_any ? S_TAIL_RD : S_POST_RD;
            end
            S_POST_RD: begin
                n_state = S_POST_EVICT;
            end
            S_POST_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = i_sts.evict_any ? S_POST_RD : S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.in_range) begin
                    // Head entries are still current, so the evict step can
                    // use them right away.
                    o_cmd.shrink = 1'b1;
                    n_state      = S_POST_EVICT;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lwwr_dpath.sv -----
`timescale 1ns / 1ps
module lwwr_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lwwr_pkg::t_cmd               i_cmd,
    output lwwr_pkg::t_sts               o_sts,
    input  lwwr_pkg::t_in                i_in_data,
    input  logic                         i_cfg_we,
    input  logic [lwwr_pkg::DATA_W-1:0]  i_cfg_wdata,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output lwwr_pkg::t_out               o_out_data
);
    import lwwr_pkg::*;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WINDOW);

    // Index 0 is the maximum queue, index 1 the minimum queue.
    logic [ADDR_W:0]          r_head [2];
    logic [ADDR_W:0]          n_head [2];
    logic [ADDR_W:0]          r_tail [2];
    logic [ADDR_W:0]          n_tail [2];
    logic [ADDR_W-1:0]        r_pos, n_pos;
    logic [LEN_W-1:0]         r_cur, n_cur;
    logic [LEN_W-1:0]         r_best, n_best;
    logic [LEN_W-1:0]         r_len, n_len;
    logic signed [DATA_W-1:0] r_sample, n_sample;
    logic                     r_last, n_last;
    logic [DATA_W-1:0]        r_thr;
    logic                     r_out_valid, n_out_valid;
    t_out                     r_out, n_out;

    t_qentry           head_q [2];
    t_qentry           tail_q [2];
    t_qentry           wentry;
    logic              we [2];
    logic [ADDR_W-1:0] raddr_tail [2];
    logic              nonempty [2];
    logic [ADDR_W-1:0] age [2];
    logic [ADDR_W:0]   age_ext [2];
    logic              evict [2];
    logic              dom [2];
    logic [DATA_W:0]   diff;
    logic [LEN_W-1:0]  best_new;

    assign wentry = '{value: r_sample, slot: r_pos};

    for (genvar g = 0; g < 2; g++) begin : g_queue
        assign raddr_tail[g] = r_tail[g][ADDR_W-1:0] - ADDR_W'(1);

        lwwr_ram #(
            .WIDTH ($bits(t_qentry)),
            .DEPTH (MAX_WINDOW)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (we[g]),
            .i_waddr   (r_tail[g][ADDR_W-1:0]),
            .i_wdata   (wentry),
            .i_raddr_a (r_head[g][ADDR_W-1:0]),
            .o_rdata_a (head_q[g]),
            .i_raddr_b (raddr_tail[g]),
            .o_rdata_b (tail_q[g])
        );
    end

    always_comb begin
        for (int q = 0; q < 2; q++) begin
            nonempty[q] = r_head[q] != r_tail[q];
            age[q]      = r_pos - head_q[q].slot;
            // Before the new sample is stored, an entry in its own slot is a
            // full window old.
            age_ext[q]  = {i_cmd.pre && (age[q] == '0), age[q]};
            evict[q]    = nonempty[q] && (age_ext[q] >= r_len);
        end
        dom[0] = nonempty[0] && (tail_q[0].value <= r_sample);
        dom[1] = nonempty[1] && (tail_q[1].value >= r_sample);
        diff   = {head_q[0].value[DATA_W-1], head_q[0].value}
               - {head_q[1].value[DATA_W-1], head_q[1].value};
    end

    assign best_new        = (r_len > r_best) ? r_len : r_best;
    assign o_sts.evict_any = evict[0] || evict[1];
    assign o_sts.dom_any   = dom[0] || dom[1];
    assign o_sts.in_range  = (diff <= {1'b0, r_thr}) || (r_len <= LEN_W'(1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_best      = r_best;
        n_len       = r_len;
        n_sample    = r_sample;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        we[0]       = 1'b0;
        we[1]       = 1'b0;

        if (i_cmd.accept) begin
            n_sample = i_in_data.sample;
            n_last   = i_in_data.last_sample;
            n_len    = (r_cur == LEN_MAX) ? LEN_MAX : r_cur + LEN_W'(1);
        end

        if (i_cmd.evict) begin
            for (int q = 0; q < 2; q++) begin
                if (evict[q]) begin
                    n_head[q] = r_head[q] + (ADDR_W+1)'(1);
                end
            end
        end

        if (i_cmd.push) begin
            if (dom[0] || dom[1]) begin
                for (int q = 0; q < 2; q++) begin
                    if (dom[q]) begin
                        n_tail[q] = r_tail[q] - (ADDR_W+1)'(1);
                    end
                end
            end else begin
                for (int q = 0; q < 2; q++) begin
                    we[q]     = 1'b1;
                    n_tail[q] = r_tail[q] + (ADDR_W+1)'(1);
                end
            end
        end

        // The window must start after the older of the two head entries.
        if (i_cmd.shrink) begin
            n_len = {1'b0, (age[0] > age[1]) ? age[0] : age[1]};
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.finish) begin
            n_out_valid      = 1'b1;
            n_out.window_len = r_len;
            n_out.best_len   = best_new;
            n_cur            = r_len;
            n_best           = best_new;
            n_pos            = r_pos + ADDR_W'(1);
            if (r_last) begin
                n_head[0] = '0;
                n_head[1] = '0;
                n_tail[0] = '0;
                n_tail[1] = '0;
                n_pos     = '0;
                n_cur     = '0;
                n_best    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head[0]   <= '0;
            r_head[1]   <= '0;
            r_tail[0]   <= '0;
            r_tail[1]   <= '0;
            r_pos       <= '0;
            r_cur       <= '0;
            r_best      <= '0;
            r_thr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_pos       <= n_pos;
            r_cur       <= n_cur;
            r_best      <= n_best;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_sample <= n_sample;
        r_last   <= n_last;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/longest_window_within_range_core.sv -----
`timescale 1ns / 1ps
// Longest window within range.
// The input channel carries one signed sample and a last-sample flag per
// transfer; the output channel returns, for each sample, the longest window
// ending there whose maximum minus minimum is at most the threshold, and the
// best length so far in the sequence. After the last sample the sequence state
// clears. The threshold is written through i_cfg_we / i_cfg_wdata, by the user
// only while idle; the block does not enforce this. Both channels use valid and
// stall; a transfer happens when valid is high and stall is low.
// One item is worked on at a time: after the input transfer the block reads and
// evicts stale heads, reads the tail and pops or pushes on the two monotonic
// queues, evicts again and checks the range; each window shrink repeats the
// evict and check steps. The queue RAMs have one registered read per port, which
// sets these steps. Pops average about one per item. The next input is taken
// the cycle after the result is registered, even while that result still waits.
// If the receiver stalls and the output register is still full, the block
// holds the finished item until the register frees.
// A synchronous reset clears the sequence, the threshold and the output valid;
// the queue RAMs need no clearing.
module longest_window_within_range_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  lwwr_pkg::t_in                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output lwwr_pkg::t_out               o_out_data,
    input  logic                         i_cfg_we,
    input  logic [lwwr_pkg::DATA_W-1:0]  i_cfg_wdata
);
    import lwwr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lwwr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lwwr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- tb/lwwr_checker.sv -----
`timescale 1ns / 1ps
module lwwr_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  lwwr_pkg::t_in               i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  lwwr_pkg::t_out              i_out_data,
    input  logic                        i_cfg_we,
    input  logic [lwwr_pkg::DATA_W-1:0] i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_results
);
    import lwwr_pkg::*;

    logic [DATA_W-1:0] range_limit;
    longint            recent[$];
    int                run_len;
    int                best_run;
    t_out              pending_lengths[$];
    int                mismatch_count;
    int                result_count;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_lengths.size();
    assign o_results    = result_count;

    // The window start only moves forward, so the new window can be at most
    // one longer than the previous one. Scanning back from the newest sample
    // finds the longest tail whose spread still fits the threshold.
    function automatic t_out predict_lengths(input t_in item);
        t_out   res;
        int     reach;
        int     len;
        longint hi;
        longint lo;
        longint v;
        longint bound;
        bit     grow;
        recent.insert(recent.size(), longint'($signed(item.sample)));
        if (recent.size() > MAX_WINDOW)
            void'(recent.pop_front());
        reach = run_len + 1;
        if (reach > MAX_WINDOW)
            reach = MAX_WINDOW;
        bound = {32'b0, range_limit};
        hi = recent[recent.size() - 1];
        lo = hi;
        len = 1;
        grow = 1'b1;
        while (grow && len < reach) begin
            v = recent[recent.size() - 1 - len];
            if (v > hi)
                hi = v;
            if (v < lo)
                lo = v;
            if (hi - lo > bound)
                grow = 1'b0;
            else
                len++;
        end
        run_len = len;
        if (len > best_run)
            best_run = len;
        res.window_len = len[LEN_W-1:0];
        res.best_len   = best_run[LEN_W-1:0];
        if (item.last_sample) begin
            recent.delete();
            run_len  = 0;
            best_run = 0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            range_limit = '0;
            recent.delete();
            run_len  = 0;
            best_run = 0;
            pending_lengths.delete();
            mismatch_count = 0;
            result_count   = 0;
        end else begin
            if (i_cfg_we)
                range_limit = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                pending_lengths.insert(pending_lengths.size(), predict_lengths(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                result_count++;
                if (pending_lengths.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got len %0d best %0d",
                             $time, i_out_data.window_len, i_out_data.best_len);
                    mismatch_count++;
                end else begin
                    want = pending_lengths.pop_front();
                    if (i_out_data.window_len !== want.window_len) begin
                        $display("%0t: window_len mismatch: expected %0d, got %0d",
                                 $time, want.window_len, i_out_data.window_len);
                        mismatch_count++;
                    end
                    if (i_out_data.best_len !== want.best_len) begin
                        $display("%0t: best_len mismatch: expected %0d, got %0d",
                                 $time, want.best_len, i_out_data.best_len);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import lwwr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 88;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in               in_data;
    logic              out_valid;
    logic              out_stall;
    t_out              out_data;
    logic              cfg_we;
    logic [DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int results;
    int cycles;
    int seq_count;
    bit no_idle;

    longest_window_within_range_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    lwwr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stall for a random number of cycles, then take one transfer.
    initial begin
        int gap;
        out_stall = 1'b0;
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                out_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            out_stall = 1'b0;
            do @(posedge i_clk); while (!out_valid);
            @(negedge i_clk);
        end
    end

    // Valid stays high after a transfer; the next call either replaces the
    // payload right away or lowers valid for its gap.
    task automatic send_sample(input logic [DATA_W-1:0] value, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data.sample      = value;
        in_data.last_sample = last;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        if (last)
            seq_count++;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_sample(input int base, input int spread);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return base + $urandom_range(0, 2 * spread) - spread;
        if (r < 9)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    initial begin
        int seq_len;
        int sent;
        int base;
        int spread;
        logic [DATA_W-1:0] thr;

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        no_idle   = 1'b0;
        seq_count = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Equal samples fit even a zero threshold; a different one breaks the run.
        write_threshold(32'd0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd6, 1'b1);
        drain();

        // The whole signed range only fits when the threshold is all ones.
        write_threshold(32'hffff_ffff);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        drain();
        write_threshold(32'hffff_fffe);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7fff_ffff, 1'b1);
        drain();

        // A one-sample sequence, then a short one that shrinks and regrows.
        write_threshold(32'd10);
        send_sample(32'd7, 1'b1);
        send_sample(32'd0, 1'b0);
        send_sample(32'd10, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'd4, 1'b0);
        send_sample(32'd9, 1'b0);
        send_sample(32'd20, 1'b0);
        send_sample(32'd20, 1'b0);
        send_sample(-32'sd5, 1'b1);
        drain();

        // Run past the full depth so the window saturates and the ring wraps,
        // then fall back to a single sample at the end.
        no_idle = 1'b1;
        write_threshold(32'd100);
        for (int i = 0; i < MAX_WINDOW + 20; i++)
            send_sample($urandom_range(0, 100), 1'b0);
        send_sample(32'd1000, 1'b1);
        no_idle = 1'b0;
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: thr = 32'd0;
                1: thr = 32'd1;
                2: thr = 32'd5;
                3: thr = 32'd12;
                4: thr = 32'hffff_ffff;
                5: thr = $urandom;
                6: thr = 32'h8000_0000;
                default: thr = $urandom_range(0, 40);
            endcase
            no_idle = (phase == 2 || phase == 5);
            write_threshold(thr);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(1, 30);
                base   = $urandom_range(0, 1) ? int'($urandom) : $urandom_range(0, 64) - 32;
                spread = $urandom_range(0, 20);
                for (int k = 0; k < seq_len; k++)
                    send_sample(pick_sample(base, spread), k == seq_len - 1);
                sent += seq_len;
            end
            drain();
        end

        $display("Checked %0d results over %0d sequences at thresholds from zero to all ones,",
                 results, seq_count);
        $display("with gaps on both channels and one sequence saturating at %0d samples.",
                 MAX_WINDOW);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
